// ===== rtl/ebl_pkg.sv =====
// Shared types and constants for the embedded block locator.
`default_nettype none

package ebl_pkg;

   localparam int unsigned OUT_BITS    = 24;
   localparam int unsigned WIDE_BITS   = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_IDX   = 2;

   // "__DATA__" packed, first character in the most significant byte
   localparam logic [63:0] MARK_WORD = 64'h5F5F_4441_5441_5F5F;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                block_found;
      logic                has_shebang;
      logic [OUT_BITS-1:0] block_start;
      logic [OUT_BITS-1:0] block_length;
      logic                too_long;
   } rsp_type;

   // Classified byte handed from the front to the back
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       is_newline;
      logic       is_tail;
      logic       is_hash;
      logic       is_bang;
      logic       is_name_char;
   } item_type;

endpackage

`default_nettype wire

// ===== rtl/embedded_block_locator_top.sv =====
// Embedded block locator: top level joining front end, byte queue and back end.
//
// Usage:
//   Bytes of a script text enter through a queue-style port: req_data is
//   transferred at a clock edge where push is high and full is low. Mark the
//   final byte of a text with last_byte; no result is produced for any other
//   byte. The single result for the text (block found, shebang, block start,
//   block length, too_long) appears on rsp_data while empty is low and is
//   transferred at an edge where pop is high.
//   Throughput is one byte per cycle while full is low: the front end classifies a byte and
//   writes it into a four-entry queue; the back end retires one queued byte
//   per cycle through its line scanner, except that a final byte waits there while a result is still held.
//   The final byte is registered in the queue and then the back end registers
//   the result; bytes already queued ahead of the final byte delay the result further.
//   When the receiver stalls, the result register holds its result; bytes
//   of the next text keep flowing until a further final byte reaches the back
//   end, which then waits, and the queue fills until full rises.
//   Reset (synchronous, active high) empties the queue, drops any waiting
//   result and returns the scanner to the start of a text.
`default_nettype none

module embedded_block_locator_top #(
   parameter int unsigned POSITION_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire ebl_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output ebl_pkg::rsp_type      rsp_data
);

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   ebl_pkg::item_type q_wr_item;
   ebl_pkg::item_type q_rd_item;

   ebl_front u_front (
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_item   (q_wr_item)
   );

   ebl_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (q_wr_item),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_item (q_rd_item),
      .q_empty (q_empty)
   );

   ebl_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (q_rd_item),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/ebl_front.sv =====
// Front end: takes bytes from the input channel and classifies them.
`default_nettype none

module ebl_front (
   input  wire logic             push,
   output logic                  full,
   input  wire ebl_pkg::req_type req_data,
   output logic                  q_push,
   input  wire logic             q_full,
   output ebl_pkg::item_type     q_item
);

   logic [7:0] b;

   always_comb begin
      b = req_data.text_byte;
      q_item.text_byte    = b;
      q_item.last_byte    = req_data.last_byte;
      q_item.is_newline   = (b == ebl_pkg::CHAR_NEWLINE);
      q_item.is_tail      = (b == ebl_pkg::CHAR_DQUOTE) || (b == ebl_pkg::CHAR_SQUOTE) ||
                            (b == ebl_pkg::CHAR_SEMI);
      q_item.is_hash      = (b == ebl_pkg::CHAR_HASH);
      q_item.is_bang      = (b == ebl_pkg::CHAR_BANG);
      q_item.is_name_char = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
                            (b >= 8'h41 && b <= 8'h5A) || (b == ebl_pkg::CHAR_DASH) ||
                            (b == ebl_pkg::CHAR_UNDER) || (b == ebl_pkg::CHAR_SPACE) ||
                            (b == ebl_pkg::CHAR_SLASH);
   end

   assign full   = q_full;
   assign q_push = push && !q_full;

endmodule

`default_nettype wire

// ===== rtl/ebl_fifo.sv =====
// Short queue of classified bytes between the front and the back.
`default_nettype none

module ebl_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire ebl_pkg::item_type wr_item,
   output logic                   q_full,
   input  wire logic              rd_en,
   output ebl_pkg::item_type      rd_item,
   output logic                   q_empty
);

   localparam logic [ebl_pkg::QUEUE_IDX:0] DEPTH = (ebl_pkg::QUEUE_IDX+1)'(ebl_pkg::QUEUE_DEPTH);

   ebl_pkg::item_type entry_ff [ebl_pkg::QUEUE_DEPTH];
   logic [ebl_pkg::QUEUE_IDX-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ebl_pkg::QUEUE_IDX-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ebl_pkg::QUEUE_IDX:0]   count_ff, count_in;

   assign q_full  = (count_ff == DEPTH);
   assign q_empty = (count_ff == '0);
   assign rd_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (wr_en ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (rd_en ? 1'b1 : 1'b0);
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ebl_back.sv =====
// Back end: line scanner state and the result register.
`default_nettype none

module ebl_back #(
   parameter int unsigned POSITION_BITS = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ebl_pkg::item_type q_item,
   input  wire logic              q_empty,
   output logic                   q_pop,
   output logic                   empty,
   input  wire logic              pop,
   output ebl_pkg::rsp_type       rsp_data
);

   typedef enum logic [3:0] {
      PH_FIRST = 4'b0001,
      PH_MARK  = 4'b0010,
      PH_CLOSE = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   localparam int unsigned P = POSITION_BITS;
   localparam int unsigned W = ebl_pkg::WIDE_BITS;
   localparam int unsigned O = ebl_pkg::OUT_BITS;

   function automatic logic [P-1:0] pos_diff(input logic [P-1:0] a, input logic [P-1:0] c);
      return (a >= c) ? (a - c) : '0;
   endfunction

   phase_type       phase_ff, phase_in;
   logic [P-1:0]    pos_ff, pos_in;
   logic [P-1:0]    line_start_ff, line_start_in;
   logic [P-1:0]    start_ff, start_in;
   logic [P-1:0]    length_ff, length_in;
   logic            first_valid_ff, first_valid_in;
   logic [3:0]      line_len_ff, line_len_in;
   logic [63:0]     recent_ff, recent_in;
   logic [63:0]     before_ff, before_in;
   logic [3:0]      before_len_ff, before_len_in;
   logic            tail_run_ff, tail_run_in;
   logic            shebang_ff, shebang_in;
   logic            found_ff, found_in;
   logic            overflow_ff, overflow_in;

   logic            rsp_valid_ff, rsp_valid_in;
   ebl_pkg::rsp_type rsp_ff, rsp_in;

   logic            out_free;
   logic            take;
   logic            take_last;
   logic            sat;
   logic [P-1:0]    next_pos;
   logic            mark_phase;
   logic [63:0]     cand;
   logic [3:0]      cand_len;
   logic            name_ok;
   logic [P-1:0]    len_open;
   logic [W-1:0]    st_w;
   logic [W-1:0]    ln_w;
   logic            st_clamp;
   logic            ln_clamp;

   assign out_free  = !rsp_valid_ff || pop;
   assign q_pop     = !q_empty && (!q_item.last_byte || out_free);
   assign take      = q_pop;
   assign take_last = take && q_item.last_byte;
   assign empty     = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sat      = (pos_ff == {P{1'b1}});
      next_pos = sat ? pos_ff : pos_ff + 1'b1;
      cand     = tail_run_ff ? before_ff : recent_ff;
      cand_len = tail_run_ff ? before_len_ff : line_len_ff;
      priority if (line_len_ff == 4'd0) begin
         name_ok = q_item.is_hash;
      end else if (line_len_ff == 4'd1) begin
         name_ok = q_item.is_bang;
      end else begin
         name_ok = q_item.is_name_char;
      end

      phase_in       = phase_ff;
      pos_in         = pos_ff;
      line_start_in  = line_start_ff;
      start_in       = start_ff;
      length_in      = length_ff;
      first_valid_in = first_valid_ff;
      line_len_in    = line_len_ff;
      recent_in      = recent_ff;
      before_in      = before_ff;
      before_len_in  = before_len_ff;
      tail_run_in    = tail_run_ff;
      shebang_in     = shebang_ff;
      found_in       = found_ff;
      overflow_in    = overflow_ff;
      mark_phase     = 1'b0;

      if (take) begin
         pos_in      = next_pos;
         overflow_in = overflow_ff || sat;
         if (q_item.is_newline) begin
            unique case (phase_ff)
               PH_FIRST: begin
                  if (first_valid_ff && line_len_ff >= 4'd4) begin
                     shebang_in = 1'b1;
                  end else begin
                     found_in = 1'b1;
                     start_in = '0;
                  end
                  mark_phase = 1'b1;
               end
               PH_MARK: begin
                  mark_phase = 1'b1;
               end
               PH_CLOSE: begin
                  if (line_len_ff == 4'd8 && recent_ff == ebl_pkg::MARK_WORD) begin
                     // an empty block measures up to the closing newline
                     length_in = pos_diff(line_start_ff, start_ff);
                     if (length_in == '0) begin
                        length_in = pos_diff(pos_ff, start_ff);
                     end
                     phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
               end
               default: begin
               end
            endcase
            if (mark_phase) begin
               phase_in = PH_MARK;
               if (cand_len >= 4'd8 && cand == ebl_pkg::MARK_WORD) begin
                  start_in = next_pos;
                  found_in = 1'b1;
                  phase_in = PH_CLOSE;
               end
            end
            recent_in     = '0;
            before_in     = '0;
            before_len_in = '0;
            tail_run_in   = 1'b0;
            line_len_in   = '0;
            line_start_in = next_pos;
         end else begin
            if (phase_ff == PH_FIRST && !name_ok) begin
               first_valid_in = 1'b0;
            end
            if (q_item.is_tail) begin
               // hold the line as it stood before the quote/semicolon run
               if (!tail_run_ff) begin
                  before_in     = recent_ff;
                  before_len_in = line_len_ff;
                  tail_run_in   = 1'b1;
               end
            end else begin
               tail_run_in = 1'b0;
            end
            recent_in = {recent_ff[55:0], q_item.text_byte};
            if (line_len_ff != 4'd15) begin
               line_len_in = line_len_ff + 1'b1;
            end
         end
      end

      len_open = pos_diff(pos_in, start_in);
      st_w     = found_in ? W'(start_in) : '0;
      ln_w     = '0;
      if (found_in) begin
         ln_w = (phase_in == PH_DONE) ? W'(length_in) : W'(len_open);
      end
      st_clamp = |st_w[W-1:O];
      ln_clamp = |ln_w[W-1:O];

      rsp_in.block_found  = found_in;
      rsp_in.has_shebang  = shebang_in;
      rsp_in.block_start  = st_clamp ? {O{1'b1}} : st_w[O-1:0];
      rsp_in.block_length = ln_clamp ? {O{1'b1}} : ln_w[O-1:0];
      rsp_in.too_long     = overflow_in || st_clamp || ln_clamp;

      rsp_valid_in = rsp_valid_ff;
      if (take_last) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || take_last) begin
         phase_ff       <= PH_FIRST;
         pos_ff         <= '0;
         line_start_ff  <= '0;
         start_ff       <= '0;
         length_ff      <= '0;
         first_valid_ff <= 1'b1;
         line_len_ff    <= '0;
         recent_ff      <= '0;
         before_ff      <= '0;
         before_len_ff  <= '0;
         tail_run_ff    <= 1'b0;
         shebang_ff     <= 1'b0;
         found_ff       <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         line_start_ff  <= line_start_in;
         start_ff       <= start_in;
         length_ff      <= length_in;
         first_valid_ff <= first_valid_in;
         line_len_ff    <= line_len_in;
         recent_ff      <= recent_in;
         before_ff      <= before_in;
         before_len_ff  <= before_len_in;
         tail_run_ff    <= tail_run_in;
         shebang_ff     <= shebang_in;
         found_ff       <= found_in;
         overflow_ff    <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_last) begin
         rsp_ff <= rsp_in;
      end
   end

   a_found_left_first: assert property (@(posedge clock) disable iff (reset)
      (found_ff || shebang_ff) |-> (phase_ff != PH_FIRST))
      else $error("found or shebang flag set while still on the first line");

   a_done_has_block: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> found_ff)
      else $error("closing line seen without a block start");

   a_offsets_behind: assert property (@(posedge clock) disable iff (reset)
      (line_start_ff <= pos_ff) && (start_ff <= pos_ff))
      else $error("line or block start ahead of byte position");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      take_last |-> out_free)
      else $error("final byte taken while result slot occupied");

   a_result_after_last: assert property (@(posedge clock) disable iff (reset)
      take_last |=> (rsp_valid_ff && pos_ff == '0 && phase_ff == PH_FIRST))
      else $error("scan state not restarted after final byte");

endmodule

`default_nettype wire

// ===== bench/embedded_block_locator_checker.sv =====
// Checker for the embedded block locator: predicts each text's result and compares it.
`timescale 1ns / 1ps

module embedded_block_locator_checker #(
   parameter int unsigned POSITION_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic             full,
   input  wire ebl_pkg::req_type req_data,
   input  wire logic             empty,
   input  wire logic             pop,
   input  wire ebl_pkg::rsp_type rsp_data,
   output int unsigned           errors,
   output int unsigned           pending,
   output int unsigned           checked,
   output int unsigned           blocks_seen,
   output int unsigned           shebangs_seen
);

   typedef enum logic [1:0] {
      PH_FIRST_LINE,
      PH_SEEK_MARKER,
      PH_SEEK_CLOSE,
      PH_CLOSED
   } scan_phase_type;

   localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;
   localparam logic [63:0] OUT_LIMIT = (64'd1 << ebl_pkg::OUT_BITS) - 64'd1;

   // scanner copy
   logic [63:0] pos, line_begin, blk_start, blk_len;
   logic [63:0] last8, pretail8;
   int unsigned line_len, pretail_len;
   scan_phase_type phase;
   bit          first_ok, in_tail, saw_shebang, found, ovf;

   ebl_pkg::rsp_type expected_q[$];

   initial begin
      errors        = 0;
      pending       = 0;
      checked       = 0;
      blocks_seen   = 0;
      shebangs_seen = 0;
   end

   function automatic bit is_name_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == ebl_pkg::CHAR_DASH || c == ebl_pkg::CHAR_UNDER ||
             c == ebl_pkg::CHAR_SPACE || c == ebl_pkg::CHAR_SLASH;
   endfunction

   function automatic logic [63:0] gap(logic [63:0] a, logic [63:0] b);
      return (a >= b) ? a - b : 64'd0;
   endfunction

   task automatic clear_line(input logic [63:0] nxt);
      last8       = '0;
      pretail8    = '0;
      pretail_len = 0;
      in_tail     = 1'b0;
      line_len    = 0;
      line_begin  = nxt;
   endtask

   task automatic restart_scan();
      pos         = '0;
      phase       = PH_FIRST_LINE;
      first_ok    = 1'b1;
      blk_start   = '0;
      blk_len     = '0;
      saw_shebang = 1'b0;
      found       = 1'b0;
      ovf         = 1'b0;
      clear_line('0);
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic last);
      logic [63:0] idx, nxt, cand, st, ln;
      int unsigned cand_len;
      scan_phase_type entered;
      bit          ok, sat;
      ebl_pkg::rsp_type r;
      idx     = pos;
      entered = phase;
      if (idx >= POS_LIMIT) begin
         ovf = 1'b1;
         nxt = POS_LIMIT;
      end else begin
         nxt = idx + 64'd1;
      end
      pos = nxt;

      if (b == ebl_pkg::CHAR_NEWLINE) begin
         if (phase == PH_FIRST_LINE) begin
            if (first_ok && line_len >= 4) begin
               saw_shebang = 1'b1;
            end else begin
               found     = 1'b1;
               blk_start = '0;
            end
            phase = PH_SEEK_MARKER;
         end
         if (phase == PH_SEEK_MARKER) begin
            // the marker is judged with any trailing quote/semicolon run stripped
            cand     = in_tail ? pretail8 : last8;
            cand_len = in_tail ? pretail_len : line_len;
            if (cand_len >= 8 && cand == ebl_pkg::MARK_WORD) begin
               blk_start = nxt;
               found     = 1'b1;
               phase     = PH_SEEK_CLOSE;
            end
         end else if (entered == PH_SEEK_CLOSE) begin
            if (line_len == 8 && last8 == ebl_pkg::MARK_WORD) begin
               blk_len = gap(line_begin, blk_start);
               if (blk_len == 0) blk_len = gap(idx, blk_start);
               phase = PH_CLOSED;
            end
         end
         clear_line(nxt);
      end else begin
         if (phase == PH_FIRST_LINE) begin
            if (line_len == 0)      ok = (b == ebl_pkg::CHAR_HASH);
            else if (line_len == 1) ok = (b == ebl_pkg::CHAR_BANG);
            else                    ok = is_name_char(b);
            if (!ok) first_ok = 1'b0;
         end
         if (b == ebl_pkg::CHAR_DQUOTE || b == ebl_pkg::CHAR_SQUOTE ||
             b == ebl_pkg::CHAR_SEMI) begin
            if (!in_tail) begin
               pretail8    = last8;
               pretail_len = line_len;
               in_tail     = 1'b1;
            end
         end else begin
            in_tail = 1'b0;
         end
         last8 = {last8[55:0], b};
         if (line_len < 15) line_len++;
      end

      if (last) begin
         sat = ovf;
         st  = '0;
         ln  = '0;
         if (found) begin
            st = blk_start;
            ln = (phase == PH_CLOSED) ? blk_len : gap(nxt, blk_start);
         end
         if (st > OUT_LIMIT) begin
            sat = 1'b1;
            st  = OUT_LIMIT;
         end
         if (ln > OUT_LIMIT) begin
            sat = 1'b1;
            ln  = OUT_LIMIT;
         end
         r.block_found  = found;
         r.has_shebang  = saw_shebang;
         r.block_start  = st[ebl_pkg::OUT_BITS-1:0];
         r.block_length = ln[ebl_pkg::OUT_BITS-1:0];
         r.too_long     = sat;
         expected_q.push_back(r);
         restart_scan();
      end
   endtask

   task automatic report_error(input string msg);
      $display("%0t ns  MISMATCH: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      ebl_pkg::rsp_type want;
      if (reset) begin
         restart_scan();
         expected_q.delete();
      end else begin
         // retire the result side first: a result never leaves on its own last byte's edge
         if (pop && !empty) begin
            if (expected_q.size() == 0) begin
               report_error($sformatf("result with none pending: start %0d length %0d",
                                      rsp_data.block_start, rsp_data.block_length));
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (rsp_data.block_found !== want.block_found)
                  report_error($sformatf("result %0d block_found got %0b want %0b", checked,
                                         rsp_data.block_found, want.block_found));
               if (rsp_data.has_shebang !== want.has_shebang)
                  report_error($sformatf("result %0d has_shebang got %0b want %0b", checked,
                                         rsp_data.has_shebang, want.has_shebang));
               if (rsp_data.block_start !== want.block_start)
                  report_error($sformatf("result %0d block_start got %0d want %0d", checked,
                                         rsp_data.block_start, want.block_start));
               if (rsp_data.block_length !== want.block_length)
                  report_error($sformatf("result %0d block_length got %0d want %0d", checked,
                                         rsp_data.block_length, want.block_length));
               if (rsp_data.too_long !== want.too_long)
                  report_error($sformatf("result %0d too_long got %0b want %0b", checked,
                                         rsp_data.too_long, want.too_long));
               if (want.block_found) blocks_seen++;
               if (want.has_shebang) shebangs_seen++;
            end
         end
         if (push && !full) scan_byte(req_data.text_byte, req_data.last_byte);
      end
      pending = expected_q.size();
   end

endmodule

// ===== bench/embedded_block_locator_top_tb.sv =====
// Testbench top for the embedded block locator: clock, reset, script-text stimulus and verdict.
`timescale 1ns / 1ps

module embedded_block_locator_top_tb;

   localparam int unsigned POS_BITS    = 24;
   localparam int unsigned ITEM_TARGET = 1950;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned LIMIT       = 200000;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   ebl_pkg::req_type req_data;
   logic    empty;
   logic    pop;
   ebl_pkg::rsp_type rsp_data;

   int unsigned errors, pending, checked, blocks_seen, shebangs_seen;

   // stimulus bookkeeping
   logic [7:0]  text_q[$];
   int unsigned texts_sent, bytes_sent, cycles;
   bit          calm;
   int unsigned hold_ticket;

   // receiver-side state
   int unsigned hold_taken, hold_left, rx_gap, rx_mode_left;
   bit          rx_bursty;

   string filler = "abqxyzAQZ0759_-/ .;'\"DAT#!\t=";
   string names  = "azmAZQ09-_ /";
   string tails  = "\"';";

   embedded_block_locator_top #(
      .POSITION_BITS(POS_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   embedded_block_locator_checker #(
      .POSITION_BITS(POS_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .errors        (errors),
      .pending       (pending),
      .checked       (checked),
      .blocks_seen   (blocks_seen),
      .shebangs_seen (shebangs_seen)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
         $display("embedded_block_locator_top verification failed");
         $finish;
      end
   end

   // receiver: random pop bursts, calm stretches, and a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (hold_taken != hold_ticket) begin
            hold_taken = hold_ticket;
            hold_left  = HOLD_CYCLES;
         end
         if (rx_mode_left == 0) begin
            rx_bursty    = ($urandom_range(0, 1) == 0);
            rx_mode_left = $urandom_range(20, 80);
         end else begin
            rx_mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (!calm && rx_bursty && $urandom_range(0, 3) == 0) rx_gap = $urandom_range(1, 9);
         end
      end
   end

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic add_from(input string s, input int unsigned n);
      repeat (n) text_q.push_back(pick(s));
   endtask

   task automatic add_filler_lines(input int unsigned n);
      repeat (n) begin
         add_from(filler, ($urandom_range(0, 7) == 0) ? $urandom_range(15, 22)
                                                       : $urandom_range(0, 12));
         text_q.push_back(ebl_pkg::CHAR_NEWLINE);
      end
   endtask

   function automatic string near_marker(int unsigned k);
      case (k)
         0:       return "__DATA_";
         1:       return "_DATA__";
         2:       return "__DATA__x";
         3:       return "__DATA__;x";
         4:       return "__data__";
         5:       return "__DATA__ ";
         6:       return "__DAT__";
         default: return "__DATA__\"';";
      endcase
   endfunction

   task automatic build_well_formed();
      case ($urandom_range(0, 3))
         0: begin
            add_str("#!");
            add_from(names, $urandom_range(0, 8));
            text_q.push_back(ebl_pkg::CHAR_NEWLINE);
         end
         1: add_filler_lines(1);
         2: ;
         default: begin
            // shebang with one random byte in it, which usually spoils it
            add_str("#!");
            add_from(names, $urandom_range(0, 4));
            text_q.push_back(8'($urandom_range(0, 255)));
            add_from(names, $urandom_range(0, 3));
            text_q.push_back(ebl_pkg::CHAR_NEWLINE);
         end
      endcase
      add_filler_lines($urandom_range(0, 2));
      add_from(filler, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0);
      add_str("__DATA__");
      add_from(tails, ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 0);
      if ($urandom_range(0, 7) != 0) begin
         text_q.push_back(ebl_pkg::CHAR_NEWLINE);
         add_filler_lines($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: add_str("__DATA__\n");
            1: add_str("__DATA__");
            2: add_str(" __DATA__\n");
            default: ;
         endcase
         add_filler_lines($urandom_range(0, 2));
         if ($urandom_range(0, 2) == 0) add_from(filler, $urandom_range(1, 6));
      end
      // occasional corruption of one byte
      if ($urandom_range(0, 9) == 0)
         text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
   endtask

   task automatic build_text();
      text_q.delete();
      case ($urandom_range(0, 9))
         7: begin
            repeat ($urandom_range(1, 40)) begin
               if ($urandom_range(0, 5) == 0) text_q.push_back(ebl_pkg::CHAR_NEWLINE);
               else                           text_q.push_back(8'($urandom_range(0, 255)));
            end
         end
         8: begin
            add_filler_lines($urandom_range(0, 1));
            add_str(near_marker($urandom_range(0, 7)));
            text_q.push_back(ebl_pkg::CHAR_NEWLINE);
            add_filler_lines($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 0) add_str(near_marker($urandom_range(0, 7)));
            if ($urandom_range(0, 1) == 0) text_q.push_back(ebl_pkg::CHAR_NEWLINE);
         end
         9: begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 2) == 0) text_q.push_back(ebl_pkg::CHAR_NEWLINE);
               else                           text_q.push_back(pick(filler));
            end
         end
         default: build_well_formed();
      endcase
   endtask

   task automatic idle_for(input int unsigned n);
      push <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // transfer each byte of text_q, marking the final one; called at a falling edge
   task automatic send_text(input bit gappy);
      for (int i = 0; i < text_q.size(); i++) begin
         push     <= 1'b1;
         req_data <= '{text_byte: text_q[i], last_byte: (i == text_q.size() - 1)};
         @(posedge clock);
         while (full) @(posedge clock);
         @(negedge clock);
         bytes_sent++;
         if (gappy && !calm && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 9));
      end
      texts_sent++;
   endtask

   initial begin
      reset        = 1'b1;
      push         = 1'b0;
      req_data     = '0;
      calm         = 1'b0;
      hold_ticket  = 0;
      hold_taken   = 0;
      hold_left    = 0;
      rx_gap       = 0;
      rx_mode_left = 0;
      rx_bursty    = 1'b0;
      texts_sent   = 0;
      bytes_sent   = 0;
      cycles       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extreme bytes, no newline, shebang and too-short shebang,
      // marker at line start with a tail before the final newline
      text_q = '{8'hFF};
      send_text(1'b0);
      text_q = '{8'h00, ebl_pkg::CHAR_NEWLINE};
      send_text(1'b0);
      text_q.delete();
      add_str("#!ab\n");
      send_text(1'b0);
      text_q.delete();
      add_str("#!a\n");
      send_text(1'b0);
      text_q.delete();
      add_str("__DATA__;\n");
      send_text(1'b0);

      while (bytes_sent < ITEM_TARGET) begin
         if (!calm && bytes_sent > ITEM_TARGET * 9 / 10) calm <= 1'b1;
         if (texts_sent == 12 || texts_sent == 40) begin
            // starve the receiver while short texts keep coming, so full rises
            hold_ticket <= hold_ticket + 1;
            repeat (8) begin
               text_q = '{pick(filler), ebl_pkg::CHAR_NEWLINE};
               send_text(1'b0);
            end
         end
         if (texts_sent == 25) begin
            push <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         build_text();
         send_text($urandom_range(0, 2) == 0);
         if (!calm && $urandom_range(0, 4) == 0) idle_for($urandom_range(1, 9));
      end

      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("covered %0d texts in %0d bytes with stalls on both sides and a full input",
               texts_sent, bytes_sent);
      $display("compared %0d results: %0d with a block, %0d with a shebang, %0d mismatches",
               checked, blocks_seen, shebangs_seen, errors);
      if (errors == 0 && pending == 0) begin
         $display("embedded_block_locator_top verification clean");
      end else begin
         $display("embedded_block_locator_top verification failed");
      end
      $finish;
   end

endmodule
